// ===== src/svsa_pkg.sv =====
// ----------------------------------------------------------------------------
// svsa_pkg: shared types and constants for the voice slot allocator
// Holds the cell command and scan token types, the status codes and the
// saturating 24-bit add.
// ----------------------------------------------------------------------------
package svsa_pkg;

	localparam int TIME_W       = 24;
	localparam int MAX_CARRIERS = 4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	// request kinds
	localparam logic REQ_NOTE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef logic [TIME_W-1:0] time_t;

	// command broadcast to every cell
	typedef struct packed {
		logic  dec;      // subtract wait from remaining time
		time_t wait_ms;
		logic  load;     // on write, load duration
		logic  mark;     // on write, continued mark value
		time_t dur;
	} cell_cmd_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic  vld;
		logic  found;    // a free slot was seen
		time_t longest;  // longest remaining time so far
	} token_t;

	function automatic time_t sat_add24(input time_t a, input time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// ===== src/svsa_cell.sv =====
// ----------------------------------------------------------------------------
// svsa_cell: one voice slot of the allocator row
// Holds a slot's remaining time and continued mark, and passes the scan
// token on to the next cell, adding its own free flag and remaining time.
// ----------------------------------------------------------------------------
module svsa_cell #(
	parameter int IW  = 4,
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  svsa_pkg::cell_cmd_t cmd,
	input  logic               wr_en,
	input  logic [CW-1:0]      open_slots,
	input  svsa_pkg::token_t   tok_in,
	input  logic [IW-1:0]      idx_in,
	output svsa_pkg::token_t   tok_out,
	output logic [IW-1:0]      idx_out
);
	import svsa_pkg::*;

	time_t         rem_q;
	logic          mark_q;
	logic          vld_q;
	logic          found_q;
	time_t         longest_q;
	logic [IW-1:0] idx_q;
	logic          opened;
	logic          free;

	assign opened = CW'(IDX) < open_slots;
	assign free   = opened && !mark_q && (rem_q == '0);

	// slot state: decrement on event, load on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			mark_q <= 1'b0;
		end else if (cmd.dec) begin
			rem_q <= (rem_q < cmd.wait_ms) ? '0 : rem_q - cmd.wait_ms;
		end else if (wr_en) begin
			mark_q <= cmd.mark;
			if (cmd.load) begin
				rem_q <= cmd.dur;
			end
		end
	end

	// token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	// token payload: first free slot and running maximum
	always_ff @(posedge clk) begin
		found_q   <= tok_in.found | free;
		longest_q <= (opened && rem_q > tok_in.longest) ? rem_q : tok_in.longest;
		idx_q     <= tok_in.found ? idx_in : IW'(IDX);
	end

	assign tok_out = '{vld: vld_q, found: found_q, longest: longest_q};
	assign idx_out = idx_q;

endmodule

// ===== src/synth_voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// One request is in flight at a time: a new request is accepted only in the
// idle state, once the previous result has gone into the output register.
// The scan token walks the row of slot cells, one cell per cycle, from the
// launch state until it leaves the last cell. Reset clears all slots at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// synth_voice_slot_allocator: voice slot allocation for timed note events
// Decrements slot times, scans the cell row for the first free slot and the
// longest remaining time, assigns a slot and reports elapsed time.
// ----------------------------------------------------------------------------
module synth_voice_slot_allocator #(
	parameter int NUM_VOICES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// voice limit register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data,
	// request stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// wait_ms, has_prev_voice, prev_voice_id, later_used, new_graph,
	// carrier_count, carrier_time_0, carrier_time_1, carrier_time_2,
	// carrier_time_3, zero fill
	input  logic [135:0] s_axis_tdata,
	// req_type
	input  logic [0:0]   s_axis_tuser,
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// voice_id, status, voice_total, total_ms, zero fill
	output logic [39:0]  m_axis_tdata
);
	import svsa_pkg::*;

	localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CW = $clog2(NUM_VOICES + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int LW = (CW > 5) ? CW : 5;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_LAUNCH = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]    state_q;
	logic [4:0]    limit_q;
	logic [CW-1:0] open_q;
	time_t         elapsed_q;

	// captured request
	logic          req_q;
	time_t         wait_q;
	logic          has_prev_q;
	logic [3:0]    prev_q;
	logic          later_q;
	logic          newg_q;
	time_t         dur_q;

	// scan result
	logic          found_q;
	logic [IW-1:0] idx_q;
	time_t         longest_q;

	logic          out_vld_q;
	logic [39:0]   out_data_q;

	logic          s_acc;
	logic          out_free;
	time_t         ct [MAX_CARRIERS];
	logic [2:0]    ccount;
	time_t         dur_c;

	cell_cmd_t     cmd;
	token_t        tok [NUM_VOICES+1];
	logic [IW-1:0] tidx [NUM_VOICES+1];
	logic [NUM_VOICES-1:0] wr_en;

	logic          ev_ok;
	logic [IW-1:0] ev_vid;
	logic          ev_new;
	logic [CW-1:0] open_next;
	logic [3:0]    r_vid;
	logic [1:0]    r_status;
	time_t         r_total;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// longest carrier duration of the request
	assign ccount = s_axis_tdata[33:31];
	assign ct[0]  = s_axis_tdata[57:34];
	assign ct[1]  = s_axis_tdata[81:58];
	assign ct[2]  = s_axis_tdata[105:82];
	assign ct[3]  = s_axis_tdata[129:106];

	always_comb begin
		logic [2:0] n;
		n     = (ccount > 3'(MAX_CARRIERS)) ? 3'(MAX_CARRIERS) : ccount;
		dur_c = '0;
		for (int i = 0; i < MAX_CARRIERS; i++) begin
			if (3'(i) < n && ct[i] > dur_c) begin
				dur_c = ct[i];
			end
		end
	end

	// voice limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_q      <= s_axis_tuser[0];
			wait_q     <= s_axis_tdata[23:0];
			has_prev_q <= s_axis_tdata[24];
			prev_q     <= s_axis_tdata[28:25];
			later_q    <= s_axis_tdata[29];
			newg_q     <= s_axis_tdata[30];
			dur_q      <= dur_c;
		end
	end

	// slot assignment for a note event
	always_comb begin
		ev_ok     = 1'b0;
		ev_vid    = '0;
		ev_new    = 1'b0;
		if (has_prev_q) begin
			ev_ok  = PW'(prev_q) < PW'(open_q);
			ev_vid = IW'(prev_q);
		end else if (found_q) begin
			ev_ok  = 1'b1;
			ev_vid = idx_q;
		end else if (open_q < CW'(NUM_VOICES)) begin
			ev_ok  = 1'b1;
			ev_new = 1'b1;
			ev_vid = IW'(open_q);
		end
		open_next = ev_new ? open_q + 1'b1 : open_q;
	end

	// result fields
	always_comb begin
		if (req_q == REQ_FINISH) begin
			r_vid    = '0;
			r_status = (LW'(open_q) > LW'(limit_q)) ? ST_LIMIT : ST_OK;
			r_total  = sat_add24(elapsed_q, longest_q);
		end else begin
			r_vid    = ev_ok ? 4'(ev_vid) : 4'd0;
			r_status = ev_ok ? ST_OK : ST_NO_SLOT;
			r_total  = elapsed_q;
		end
	end

	// broadcast command to the cells
	always_comb begin
		cmd.dec     = (state_q == S_DEC) && (req_q == REQ_NOTE);
		cmd.wait_ms = wait_q;
		cmd.load    = newg_q;
		cmd.mark    = later_q;
		cmd.dur     = dur_q;
	end

	// write strobe per slot at commit
	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			wr_en[i] = (state_q == S_COMMIT) && out_free && (req_q == REQ_NOTE)
				&& ev_ok && (ev_vid == IW'(i));
		end
	end

	// scan token entry
	assign tok[0].vld     = (state_q == S_LAUNCH);
	assign tok[0].found   = 1'b0;
	assign tok[0].longest = '0;
	assign tidx[0]        = '0;

	// row of slot cells
	for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
		svsa_cell #(
			.IW  (IW),
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.wr_en      (wr_en[g]),
			.open_slots (open_q),
			.tok_in     (tok[g]),
			.idx_in     (tidx[g]),
			.tok_out    (tok[g+1]),
			.idx_out    (tidx[g+1])
		);
	end

	// scan result capture
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && tok[NUM_VOICES].vld) begin
			found_q   <= tok[NUM_VOICES].found;
			idx_q     <= tidx[NUM_VOICES];
			longest_q <= tok[NUM_VOICES].longest;
		end
	end

	// sequencer, slot count and elapsed time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			open_q    <= '0;
			elapsed_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (req_q == REQ_NOTE) begin
						elapsed_q <= sat_add24(elapsed_q, wait_q);
					end
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (tok[NUM_VOICES].vld) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						if (req_q == REQ_NOTE) begin
							open_q <= open_next;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_COMMIT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_COMMIT && out_free) begin
			out_data_q <= {5'd0, r_total,
				(req_q == REQ_NOTE) ? 5'(open_next) : 5'(open_q),
				r_status, r_vid};
		end
	end

endmodule

// ===== bench/synth_voice_slot_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// synth_voice_slot_allocator_tb: self-checking bench for the voice allocator
// Drives note and finish requests through the request stream and predicts
// every result with a cycle-free model of the slot table. Covers directed
// corner cases, a full table, several voice limits, random traffic under
// four idle patterns, and elapsed time saturation.
// ----------------------------------------------------------------------------
module synth_voice_slot_allocator_tb;
	import svsa_pkg::*;

	localparam int NUM_VOICES   = 16;
	localparam int SETTLE_CYCLES = NUM_VOICES + 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;

	// one request as the bench sees it
	typedef struct {
		logic                        req_type;
		time_t                       wait_ms;
		logic                        has_prev_voice;
		logic [3:0]                  prev_voice_id;
		logic                        later_used;
		logic                        new_graph;
		logic [2:0]                  carrier_count;
		time_t [MAX_CARRIERS-1:0]    carrier_time;
	} note_req_t;

	typedef struct packed {
		logic [3:0] voice_id;
		logic [1:0] status;
		logic [4:0] voice_total;
		time_t      total_ms;
	} alloc_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [4:0]   cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// wait_ms, has_prev_voice, prev_voice_id, later_used, new_graph,
	// carrier_count, carrier_time_0..3, zero fill
	logic [135:0] s_axis_tdata = '0;
	// req_type
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// voice_id, status, voice_total, total_ms, zero fill
	logic [39:0]  m_axis_tdata;

	// predicted slot table
	time_t      voice_time [NUM_VOICES];
	logic       voice_marked [NUM_VOICES];
	logic [4:0] slots_open;
	time_t      elapsed_ms;
	logic [4:0] voice_limit_reg;

	alloc_result_t expected_results [$];
	int fail_count = 0;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	synth_voice_slot_allocator #(
		.NUM_VOICES(NUM_VOICES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// saturating 24-bit accumulate
	function automatic time_t add_clamped(input time_t a, input time_t b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// predict the result of one request and advance the slot table
	function automatic alloc_result_t predict_allocation(input note_req_t r);
		alloc_result_t res;
		time_t         longest;
		time_t         dur;
		logic [3:0]    vid;
		bit            found;
		int            n;
		res = '0;
		found = 0;
		vid = '0;
		if (r.req_type == REQ_FINISH) begin
			longest = '0;
			for (int i = 0; i < NUM_VOICES; i++)
				if (i < slots_open && voice_time[i] > longest) longest = voice_time[i];
			res.total_ms = add_clamped(elapsed_ms, longest);
			res.status = (slots_open > voice_limit_reg) ? ST_LIMIT : ST_OK;
		end else begin
			// age every open slot
			for (int i = 0; i < NUM_VOICES; i++)
				if (i < slots_open)
					voice_time[i] = (voice_time[i] < r.wait_ms) ? '0
						: voice_time[i] - r.wait_ms;
			// pick a slot: named voice, lowest free slot, or a fresh one
			if (r.has_prev_voice) begin
				if (r.prev_voice_id < slots_open) begin
					vid = r.prev_voice_id;
					found = 1;
				end
			end else begin
				for (int i = 0; i < NUM_VOICES; i++)
					if (!found && i < slots_open && !voice_marked[i]
							&& voice_time[i] == '0) begin
						vid = i[3:0];
						found = 1;
					end
				if (!found && slots_open < NUM_VOICES) begin
					vid = slots_open[3:0];
					voice_time[vid] = '0;
					voice_marked[vid] = 1'b0;
					slots_open = slots_open + 5'd1;
					found = 1;
				end
			end
			if (found) begin
				voice_marked[vid] = r.later_used;
				if (r.new_graph) begin
					n = (r.carrier_count > MAX_CARRIERS) ? MAX_CARRIERS : r.carrier_count;
					dur = '0;
					for (int i = 0; i < MAX_CARRIERS; i++)
						if (i < n && r.carrier_time[i] > dur) dur = r.carrier_time[i];
					voice_time[vid] = dur;
				end
				res.voice_id = vid;
				res.status = ST_OK;
			end else begin
				res.voice_id = '0;
				res.status = ST_NO_SLOT;
			end
			elapsed_ms = add_clamped(elapsed_ms, r.wait_ms);
			res.total_ms = elapsed_ms;
		end
		res.voice_total = slots_open;
		return res;
	endfunction

	function automatic note_req_t note_event(input int wait_ms, input int has_prev,
			input int prev_id, input int later, input int new_graph,
			input int count, input int c0, input int c1, input int c2,
			input int c3);
		note_req_t r;
		r.req_type = REQ_NOTE;
		r.wait_ms = TIME_W'(wait_ms);
		r.has_prev_voice = 1'(has_prev);
		r.prev_voice_id = 4'(prev_id);
		r.later_used = 1'(later);
		r.new_graph = 1'(new_graph);
		r.carrier_count = 3'(count);
		r.carrier_time[0] = TIME_W'(c0);
		r.carrier_time[1] = TIME_W'(c1);
		r.carrier_time[2] = TIME_W'(c2);
		r.carrier_time[3] = TIME_W'(c3);
		return r;
	endfunction

	// finish request with every ignored field scrambled
	function automatic note_req_t finish_event();
		note_req_t r;
		r = note_event($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1),
			$urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 7), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF));
		r.req_type = REQ_FINISH;
		return r;
	endfunction

	// send one request; prediction is taken at the accepting edge
	task automatic send_request(input note_req_t r);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.req_type;
		s_axis_tdata <= {6'b0, r.carrier_time[3], r.carrier_time[2], r.carrier_time[1],
			r.carrier_time[0], r.carrier_count, r.new_graph, r.later_used,
			r.prev_voice_id, r.has_prev_voice, r.wait_ms};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_results.push_back(predict_allocation(r));
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_voice_limit(input logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		voice_limit_reg = value;
		@(posedge clk);
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.voice_id = m_axis_tdata[3:0];
			got.status = m_axis_tdata[5:4];
			got.voice_total = m_axis_tdata[10:6];
			got.total_ms = m_axis_tdata[34:11];
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: result with none pending: %s %0d %0d %0d %0d",
						$realtime, "voice/status/total/ms", got.voice_id,
						got.status, got.voice_total, got.total_ms);
			end else begin
				want = expected_results.pop_front();
				if (got.voice_id !== want.voice_id || got.status !== want.status ||
						got.voice_total !== want.voice_total ||
						got.total_ms !== want.total_ms) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display({"%0t: mismatch exp voice %0d status %0d total %0d ",
							"ms %0d, got voice %0d status %0d total %0d ms %0d"},
							$realtime, want.voice_id, want.status, want.voice_total,
							want.total_ms, got.voice_id, got.status, got.voice_total,
							got.total_ms);
				end
			end
		end
	end

	// finish on an empty table
	task automatic test_empty_finish();
		send_request(finish_event());
		wait_for_results();
	endtask

	// slot choice, carrier handling and continuation rules
	task automatic test_slot_assignment();
		send_request(note_event(0, 0, 0, 0, 1, 1, 100, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
		send_request(note_event(0, 0, 5, 1, 1, 4, 5, 900, 7, 300));
		// named slot not open yet
		send_request(note_event(10, 1, 9, 1, 1, 2, 500, 500, 0, 0));
		// zero carriers loads a zero duration
		send_request(note_event(0, 0, 0, 0, 1, 0, 700, 800, 900, 1000));
		// no new graph keeps the cleared time of a reused slot
		send_request(note_event(0, 0, 0, 0, 0, 3, 700, 800, 900, 1000));
		// carrier count above the maximum is clamped, top duration wins
		send_request(note_event(0, 0, 0, 0, 1, 7, 1, 2, 3, 24'hFFFFFF));
		send_request(note_event(5, 1, 2, 0, 1, 2, 40, 60, 24'hFFFFFF, 24'hFFFFFF));
		send_request(note_event(5, 0, 0, 0, 1, 5, 300, 20, 250, 10));
		// continue the marked slot without a new graph
		send_request(note_event(20, 1, 1, 0, 0, 4, 9, 9, 9, 9));
		send_request(finish_event());
		// long wait frees everything, lowest slot is reused
		send_request(note_event(1000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(note_event(0, 0, 0, 1, 1, 1, 24'hFFFFFF, 0, 0, 0));
		send_request(note_event(3, 1, 0, 0, 1, 1, 70, 0, 0, 0));
		send_request(finish_event());
		wait_for_results();
	endtask

	// fill every slot, then overflow it and try each finish limit
	task automatic test_table_full();
		while (slots_open < NUM_VOICES)
			send_request(note_event(1, 0, 0, 1, 1, 1, 60000, 0, 0, 0));
		send_request(note_event(1, 0, 0, 1, 1, 1, 60000, 0, 0, 0));
		send_request(finish_event());
		wait_for_results();
		write_voice_limit(5'd15);
		send_request(finish_event());
		wait_for_results();
		write_voice_limit(5'd0);
		send_request(finish_event());
		wait_for_results();
		write_voice_limit(5'd1);
		send_request(finish_event());
		wait_for_results();
	endtask

	// random traffic under each idle pattern
	task automatic test_random_traffic();
		int        src_pct [4];
		int        sink_pct [4];
		note_req_t r;
		int        marked [$];
		src_pct = '{0, 68, 0, 21};
		sink_pct = '{0, 0, 68, 21};
		for (int phase = 0; phase < 4; phase++) begin
			write_voice_limit(phase == 0 ? 5'd16 : 5'($urandom_range(1, 16)));
			src_idle_pct = src_pct[phase];
			sink_stall_pct = sink_pct[phase];
			for (int k = 0; k < 130; k++) begin
				if ($urandom_range(0, 99) < 8) begin
					r = finish_event();
				end else begin
					r = finish_event();
					r.req_type = REQ_NOTE;
					r.wait_ms = TIME_W'(($urandom_range(0, 9) == 0)
						? $urandom_range(0, 65535) : $urandom_range(0, 1500));
					r.has_prev_voice = ($urandom_range(0, 99) < 40);
					marked.delete();
					for (int i = 0; i < NUM_VOICES; i++)
						if (i < slots_open && voice_marked[i]) marked.push_back(i);
					// mostly continue a voice that is waiting to be continued
					if (r.has_prev_voice && marked.size() != 0 && $urandom_range(0, 9) < 7)
						r.prev_voice_id = 4'(marked[$urandom_range(0, marked.size() - 1)]);
					r.later_used = ($urandom_range(0, 99) < 30);
					r.new_graph = ($urandom_range(0, 99) < 70);
					for (int i = 0; i < MAX_CARRIERS; i++)
						if (i < r.carrier_count)
							r.carrier_time[i] = TIME_W'($urandom_range(0, 4000));
				end
				send_request(r);
			end
			wait_for_results();
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	// huge waits clear every slot and pin elapsed time at its ceiling
	task automatic test_elapsed_saturation();
		write_voice_limit(5'd16);
		send_request(note_event(24'h800000, 0, 0, 1, 1, 2, 30, 24'hFFFFFF, 0, 0));
		send_request(finish_event());
		send_request(note_event(24'hFFFFFF, 0, 0, 0, 1, 1, 12, 0, 0, 0));
		send_request(note_event(0, 1, 15, 0, 1, 4, 24'hFFFFFF, 1, 2, 3));
		send_request(finish_event());
		send_request(note_event(24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(finish_event());
		wait_for_results();
	endtask

	initial begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			voice_time[i] = '0;
			voice_marked[i] = 1'b0;
		end
		slots_open = '0;
		elapsed_ms = '0;
		voice_limit_reg = 5'd16;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_finish();
		test_slot_assignment();
		test_table_full();
		test_random_traffic();
		test_elapsed_saturation();

		if (fail_count == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== synth_voice_slot_allocator.f =====
src/svsa_pkg.sv
src/svsa_cell.sv
src/synth_voice_slot_allocator.sv
bench/synth_voice_slot_allocator_tb.sv
